@@ hdl/xmid_pkg.sv @@
// shared types, opcode constants and helpers for the x86 mov decoder
// no dependencies; imported by xmid_step, x86_mov_instruction_decoder_top and tb_top

package xmid_pkg;

   localparam int MAX_INSTR_BYTES_DEF = 15;

   localparam logic [7:0] OPC_ESCAPE   = 8'h0f;
   localparam logic [7:0] OPC_MOV_LO   = 8'h88;
   localparam logic [7:0] OPC_MOV_HI   = 8'h8c;
   localparam logic [7:0] OPC_MOV_IMM8 = 8'hc6;
   localparam logic [7:0] OPC_MOV_IMM  = 8'hc7;
   localparam logic [7:0] OPC_MOVQ     = 8'h6f;

   localparam logic [7:0] PFX_ES    = 8'h26;
   localparam logic [7:0] PFX_CS    = 8'h2e;
   localparam logic [7:0] PFX_SS    = 8'h36;
   localparam logic [7:0] PFX_DS    = 8'h3e;
   localparam logic [7:0] PFX_FS    = 8'h64;
   localparam logic [7:0] PFX_GS    = 8'h65;
   localparam logic [7:0] PFX_OPSZ  = 8'h66;
   localparam logic [7:0] PFX_ADSZ  = 8'h67;

   localparam logic [7:0] MODRM_REG_MASK = 8'b0011_1000;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_INVALID   = 3'd1;
   localparam logic [2:0] ST_NO_OPCODE = 3'd2;
   localparam logic [2:0] ST_TRUNCATED = 3'd3;
   localparam logic [2:0] ST_TOO_LONG  = 3'd4;

   localparam logic [2:0] SIZE_BYTE  = 3'd1;
   localparam logic [2:0] SIZE_WORD  = 3'd2;
   localparam logic [2:0] SIZE_DWORD = 3'd4;

   localparam logic [2:0] IMM_CNT_MAX = 3'd7;

   localparam int RSP_DATA_W = 48;

   typedef enum logic [1:0] {
      PH_PREFIX,
      PH_ESC,
      PH_MODRM,
      PH_TAIL
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic        size16_seen;
      logic        escaped;
      logic [7:0]  opcode_held;
      logic [2:0]  reg_field;
      logic [31:0] tail_bytes;
      logic [2:0]  imm_count;
      logic [2:0]  error_code;
   } dec_state_type;

   localparam dec_state_type DEC_STATE_RESET = '{
      phase:       PH_PREFIX,
      size16_seen: 1'b0,
      escaped:     1'b0,
      opcode_held: 8'h00,
      reg_field:   3'd0,
      tail_bytes:  32'h0,
      imm_count:   3'd0,
      error_code:  ST_OK
   };

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  operand_bytes;
      logic [31:0] immediate_value;
      logic [2:0]  register_number;
      logic        uses_register;
      logic        op_class;
   } dec_result_type;

   function automatic logic is_legacy_prefix(input logic [7:0] b);
      return b == PFX_ES || b == PFX_CS || b == PFX_SS || b == PFX_DS ||
             b == PFX_FS || b == PFX_GS || b == PFX_OPSZ || b == PFX_ADSZ;
   endfunction

   function automatic logic is_mov_opcode(input logic [7:0] b);
      return (b >= OPC_MOV_LO && b <= OPC_MOV_HI) || b == OPC_MOV_IMM8 ||
             b == OPC_MOV_IMM;
   endfunction

endpackage

@@ hdl/xmid_step.sv @@
// one-byte decode step: next decoder state and the result for a final byte
// depends on xmid_pkg

module xmid_step #(
   parameter int MAX_INSTR_BYTES = xmid_pkg::MAX_INSTR_BYTES_DEF,
   parameter int CNT_W           = $clog2(MAX_INSTR_BYTES + 1)
) (
   input  xmid_pkg::dec_state_type  state_cur,
   input  logic [CNT_W-1:0]         count_cur,
   input  logic [7:0]               code_byte,
   output xmid_pkg::dec_state_type  state_nxt,
   output logic [CNT_W-1:0]         count_nxt,
   output xmid_pkg::dec_result_type result
);
   import xmid_pkg::*;

   logic       cnt_full;
   logic [2:0] err_pre;
   logic [2:0] size;
   logic       imm_form;
   logic [2:0] status;

   assign cnt_full  = count_cur >= CNT_W'(MAX_INSTR_BYTES);
   assign count_nxt = cnt_full ? count_cur : count_cur + CNT_W'(1);
   assign err_pre   = cnt_full ? ST_TOO_LONG : state_cur.error_code;

   always_comb begin
      // phase and error code
      state_nxt.phase      = state_cur.phase;
      state_nxt.error_code = err_pre;
      if (err_pre == ST_OK) begin
         unique case (state_cur.phase)
            PH_PREFIX: begin
               if (is_legacy_prefix(code_byte)) begin
                  state_nxt.phase = PH_PREFIX;
               end else if (code_byte == OPC_ESCAPE) begin
                  state_nxt.phase = PH_ESC;
               end else if (is_mov_opcode(code_byte)) begin
                  state_nxt.phase = PH_MODRM;
               end else begin
                  state_nxt.error_code = ST_INVALID;
               end
            end
            PH_ESC: begin
               if (code_byte == OPC_MOVQ) begin
                  state_nxt.phase = PH_MODRM;
               end else begin
                  state_nxt.error_code = ST_INVALID;
               end
            end
            PH_MODRM: state_nxt.phase = PH_TAIL;
            PH_TAIL:  state_nxt.phase = PH_TAIL;
            default:  state_nxt.phase = state_cur.phase;
         endcase
      end

      // data held across the instruction
      state_nxt.size16_seen = state_cur.size16_seen;
      state_nxt.escaped     = state_cur.escaped;
      state_nxt.opcode_held = state_cur.opcode_held;
      state_nxt.reg_field   = state_cur.reg_field;
      state_nxt.tail_bytes  = state_cur.tail_bytes;
      state_nxt.imm_count   = state_cur.imm_count;
      if (err_pre == ST_OK) begin
         unique case (state_cur.phase)
            PH_PREFIX: begin
               if (code_byte == PFX_OPSZ) begin
                  state_nxt.size16_seen = 1'b1;
               end
               if (code_byte == OPC_ESCAPE) begin
                  state_nxt.escaped = 1'b1;
               end else if (!is_legacy_prefix(code_byte)) begin
                  state_nxt.opcode_held = code_byte;
               end
            end
            PH_ESC: state_nxt.opcode_held = code_byte;
            PH_MODRM: begin
               state_nxt.reg_field = 3'((code_byte & MODRM_REG_MASK) >> 3);
               state_nxt.imm_count = 3'd0;
            end
            PH_TAIL: begin
               if (state_cur.imm_count < IMM_CNT_MAX) begin
                  state_nxt.imm_count = state_cur.imm_count + 3'd1;
               end
               // newest byte lands in the top lane
               state_nxt.tail_bytes = {code_byte, state_cur.tail_bytes[31:8]};
            end
            default: state_nxt.imm_count = state_cur.imm_count;
         endcase
      end
   end

   assign size = state_nxt.size16_seen     ? SIZE_WORD :
                 state_nxt.opcode_held[0]  ? SIZE_DWORD : SIZE_BYTE;
   assign imm_form = !state_nxt.escaped &&
                     (state_nxt.opcode_held == OPC_MOV_IMM8 ||
                      state_nxt.opcode_held == OPC_MOV_IMM);

   always_comb begin
      priority if (state_nxt.error_code != ST_OK) begin
         status = state_nxt.error_code;
      end else if (state_nxt.phase == PH_PREFIX) begin
         status = ST_NO_OPCODE;
      end else if (state_nxt.phase != PH_TAIL) begin
         status = ST_TRUNCATED;
      end else if (imm_form && state_nxt.imm_count < size) begin
         status = ST_TRUNCATED;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      result = '0;
      result.status = status;
      if (status == ST_OK) begin
         result.op_class      = state_nxt.escaped;
         result.operand_bytes = size;
         if (imm_form) begin
            unique case (size)
               SIZE_BYTE: result.immediate_value = {24'h0, state_nxt.tail_bytes[31:24]};
               SIZE_WORD: result.immediate_value = {16'h0, state_nxt.tail_bytes[31:16]};
               default:   result.immediate_value = state_nxt.tail_bytes;
            endcase
         end else begin
            result.uses_register   = 1'b1;
            result.register_number = state_nxt.reg_field;
         end
      end
   end

endmodule

@@ hdl/x86_mov_instruction_decoder_top.sv @@
// top level of the x86 mov decoder: byte stream in, one decoded result per instruction
// depends on xmid_pkg and xmid_step
//
// usage: instruction bytes enter on the req_ stream one word per cycle in fetch
// order while req_tready is high, req_tlast set on the final byte of the instruction.
// each byte updates the decoder state held in registers; the final byte also loads the
// result register, which drives the rsp_ stream. bytes without req_tlast give no word.
// latency: the result word is valid in the cycle after the final byte is taken.
// throughput: one byte per cycle unless stalled, set by the single state update between
// the state registers and the result register; instructions may follow back to back.
// the result register is a pipeline stage: req_tready is high while it is empty
// or being emptied, so a stalled rsp_tready holds the result and stops the
// input only once a result is waiting.
// reset clears the decoder state and the result valid flag; the block is ready
// in the first cycle after reset is released.
// rsp_tdata holds status, operand size, immediate or register number, and class.

module x86_mov_instruction_decoder_top #(
   parameter int MAX_INSTR_BYTES = xmid_pkg::MAX_INSTR_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] code_byte
   input  logic                            req_tlast,  // end_of_instr
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] op_class, [1] uses_register, [4:2] register_number,
   // [36:5] immediate_value, [39:37] operand_bytes, [42:40] status, [47:43] zero
   output logic [xmid_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import xmid_pkg::*;

   localparam int CNT_W = $clog2(MAX_INSTR_BYTES + 1);

   dec_state_type  state_ff, state_in, state_step;
   logic [CNT_W-1:0] count_ff, count_in, count_step;
   dec_result_type result_ff, result_in, result_step;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           req_acc;

   xmid_step #(
      .MAX_INSTR_BYTES (MAX_INSTR_BYTES),
      .CNT_W           (CNT_W)
   ) u_step (
      .state_cur (state_ff),
      .count_cur (count_ff),
      .code_byte (req_tdata),
      .state_nxt (state_step),
      .count_nxt (count_step),
      .result    (result_step)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (req_acc) begin
         if (req_tlast) begin
            // final byte: publish and start afresh
            state_in     = DEC_STATE_RESET;
            count_in     = '0;
            result_in    = result_step;
            rsp_valid_in = 1'b1;
         end else begin
            state_in = state_step;
            count_in = count_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= DEC_STATE_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - $bits(dec_result_type))'(0), result_ff};

   // a final byte always yields a word in the next cycle
   a_last_gives_word : assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tlast |=> rsp_tvalid)
      else $error("final byte gave no result word");

   // an error word carries nothing but its status
   a_error_fields_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result_ff.status != ST_OK |->
         result_ff.operand_bytes == 3'd0 && result_ff.immediate_value == 32'h0 &&
         !result_ff.uses_register && !result_ff.op_class)
      else $error("error word has non-zero fields");

   // register form never reports an immediate
   a_reg_no_imm : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result_ff.uses_register |-> result_ff.immediate_value == 32'h0)
      else $error("register form with immediate");

   // byte counter saturates at the limit
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_INSTR_BYTES))
      else $error("byte counter beyond limit");

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for x86_mov_instruction_decoder_top: directed and random byte streams
// depends on xmid_pkg and the decoder rtl; a scoreboard class predicts each result word
`timescale 1ns / 1ps

module tb_top;
   import xmid_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BYTES    = 430;

   localparam logic [7:0] PREFIXES [8] = '{PFX_ES, PFX_CS, PFX_SS, PFX_DS,
                                           PFX_FS, PFX_GS, PFX_OPSZ, PFX_ADSZ};
   localparam logic [7:0] MOV_OPCODES [7] = '{OPC_MOV_LO, OPC_MOV_LO + 8'd1,
                                              OPC_MOV_LO + 8'd2, OPC_MOV_LO + 8'd3,
                                              OPC_MOV_HI, OPC_MOV_IMM8, OPC_MOV_IMM};

   // {last, byte} pairs: register, immediate and movq forms, then invalid, no-opcode and truncated errors
   localparam logic [8:0] DIRECTED_SEQ [29] = '{
      {1'b0, OPC_MOV_LO}, {1'b1, 8'hc0},
      {1'b0, PFX_OPSZ}, {1'b0, OPC_MOV_LO + 8'd3}, {1'b1, 8'h38},
      {1'b0, OPC_MOV_HI}, {1'b1, 8'hff},
      {1'b0, OPC_MOV_IMM8}, {1'b0, 8'h05}, {1'b1, 8'h00},
      {1'b0, OPC_MOV_IMM}, {1'b0, 8'h00}, {1'b0, 8'h78}, {1'b0, 8'h56},
      {1'b0, 8'h34}, {1'b1, 8'h12},
      {1'b0, OPC_ESCAPE}, {1'b0, OPC_MOVQ}, {1'b1, 8'h08},
      {1'b1, 8'h90},
      {1'b1, PFX_ADSZ},
      {1'b1, OPC_ESCAPE},
      {1'b1, OPC_MOV_IMM},
      {1'b0, PFX_OPSZ}, {1'b0, OPC_MOV_IMM}, {1'b0, 8'h00}, {1'b1, 8'hab},
      {1'b0, OPC_ESCAPE}, {1'b1, PFX_OPSZ}
   };

   class mov_decode_scoreboard;
      phase_type      stage;
      logic           wide16;
      logic           two_byte;
      logic [7:0]     opc;
      logic [2:0]     regsel;
      logic [31:0]    trailer;
      logic [3:0]     seen;
      logic [2:0]     fault;
      logic [2:0]     imm_seen;
      dec_result_type decoded_q[$];
      int             errors;

      function new();
         clear();
         errors = 0;
      endfunction

      function void clear();
         stage    = PH_PREFIX;
         wide16   = 1'b0;
         two_byte = 1'b0;
         opc      = 8'h00;
         regsel   = 3'd0;
         trailer  = 32'h0;
         seen     = 4'd0;
         fault    = ST_OK;
         imm_seen = 3'd0;
      endfunction

      function int pending();
         return decoded_q.size();
      endfunction

      function void note_byte(logic [7:0] b, logic fin);
         logic [2:0]     size;
         logic [2:0]     st;
         logic           imm_form;
         dec_result_type r;
         if (seen >= 4'(MAX_INSTR_BYTES_DEF)) begin
            fault = ST_TOO_LONG;
         end else begin
            seen = seen + 4'd1;
         end
         if (fault == ST_OK) begin
            case (stage)
               PH_PREFIX: begin
                  if (b == PFX_ES || b == PFX_CS || b == PFX_SS || b == PFX_DS ||
                      b == PFX_FS || b == PFX_GS || b == PFX_OPSZ || b == PFX_ADSZ) begin
                     if (b == PFX_OPSZ) wide16 = 1'b1;
                  end else if (b == OPC_ESCAPE) begin
                     two_byte = 1'b1;
                     stage    = PH_ESC;
                  end else begin
                     opc = b;
                     if ((b >= OPC_MOV_LO && b <= OPC_MOV_HI) ||
                         b == OPC_MOV_IMM8 || b == OPC_MOV_IMM)
                        stage = PH_MODRM;
                     else
                        fault = ST_INVALID;
                  end
               end
               PH_ESC: begin
                  opc = b;
                  if (b == OPC_MOVQ) stage = PH_MODRM;
                  else fault = ST_INVALID;
               end
               PH_MODRM: begin
                  regsel   = 3'((b & MODRM_REG_MASK) >> 3);
                  imm_seen = 3'd0;
                  stage    = PH_TAIL;
               end
               default: begin
                  if (imm_seen < IMM_CNT_MAX) imm_seen = imm_seen + 3'd1;
                  // newest byte lands in the top, so the last bytes read little-endian
                  trailer = {b, trailer[31:8]};
               end
            endcase
         end
         if (!fin) return;

         size     = wide16 ? SIZE_WORD : (opc[0] ? SIZE_DWORD : SIZE_BYTE);
         imm_form = !two_byte && (opc == OPC_MOV_IMM8 || opc == OPC_MOV_IMM);
         if (fault != ST_OK)                   st = fault;
         else if (stage == PH_PREFIX)          st = ST_NO_OPCODE;
         else if (stage != PH_TAIL)            st = ST_TRUNCATED;
         else if (imm_form && imm_seen < size) st = ST_TRUNCATED;
         else                                  st = ST_OK;

         r = '0;
         r.status = st;
         if (st == ST_OK) begin
            r.op_class      = two_byte;
            r.operand_bytes = size;
            if (imm_form) begin
               r.immediate_value = trailer >> (32 - 8 * int'(size));
            end else begin
               r.uses_register   = 1'b1;
               r.register_number = regsel;
            end
         end
         decoded_q.push_back(r);
         clear();
      endfunction

      function void compare_field(string what, logic [31:0] exp_val, logic [31:0] act_val);
         if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0h actual %0h",
                     $time, what, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] word);
         dec_result_type got;
         dec_result_type want;
         got = dec_result_type'(word[$bits(dec_result_type)-1:0]);
         if (decoded_q.size() == 0) begin
            $display("%0t: unexpected result word, expected none actual %0h", $time, word);
            errors++;
            return;
         end
         want = decoded_q.pop_front();
         compare_field("op_class", 32'(want.op_class), 32'(got.op_class));
         compare_field("uses_register", 32'(want.uses_register), 32'(got.uses_register));
         compare_field("register_number", 32'(want.register_number),
                       32'(got.register_number));
         compare_field("immediate_value", want.immediate_value, got.immediate_value);
         compare_field("operand_bytes", 32'(want.operand_bytes), 32'(got.operand_bytes));
         compare_field("status", 32'(want.status), 32'(got.status));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = 8'h00;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   mov_decode_scoreboard sb = new();

   always #1 clock = ~clock;

   x86_mov_instruction_decoder_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // values read here are those from before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("** x86_mov_instruction_decoder_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // mostly well-formed instructions with random content, some noise and broken ones
   task automatic send_random_instr(output int n_sent);
      logic [7:0] ins[$];
      logic [7:0] opc;
      logic       wide16;
      logic       two_byte;
      int         kind;
      int         npfx;
      int         ntail;
      int         size;
      kind     = $urandom_range(99);
      wide16   = 1'b0;
      two_byte = 1'b0;
      if (kind < 8) begin
         repeat ($urandom_range(1, 18)) ins.push_back(8'($urandom_range(255)));
      end else begin
         // long prefix runs can reach the length limit
         npfx = (kind < 14) ? $urandom_range(8, 16) : $urandom_range(0, 3);
         repeat (npfx) begin
            ins.push_back(PREFIXES[$urandom_range(7)]);
            if (ins[$] == PFX_OPSZ) wide16 = 1'b1;
         end
         if ($urandom_range(4) == 0) begin
            two_byte = 1'b1;
            ins.push_back(OPC_ESCAPE);
            opc = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : OPC_MOVQ;
         end else begin
            opc = ($urandom_range(19) == 0) ? 8'($urandom_range(255))
                                            : MOV_OPCODES[$urandom_range(6)];
         end
         ins.push_back(opc);
         ins.push_back(8'($urandom_range(255)));
         size = wide16 ? 2 : (opc[0] ? 4 : 1);
         if (!two_byte && (opc == OPC_MOV_IMM8 || opc == OPC_MOV_IMM))
            ntail = ($urandom_range(5) == 0) ? $urandom_range(0, 6) : size;
         else
            ntail = $urandom_range(0, 4);
         repeat (ntail) ins.push_back(8'($urandom_range(255)));
         if ($urandom_range(15) == 0) ins = ins[0:$urandom_range(ins.size() - 1)];
      end
      foreach (ins[i]) send_byte(ins[i], i == ins.size() - 1);
      n_sent = ins.size();
   endtask

   // drop req_tvalid and let the final byte reach the scoreboard before polling
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int n;
      int sender_idle [4];
      int receiver_stall [4];
      sender_idle    = '{0, 73, 0, 8};
      receiver_stall = '{0, 0, 73, 8};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_SEQ[i]) send_byte(DIRECTED_SEQ[i][7:0], DIRECTED_SEQ[i][8]);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = sender_idle[ph];
         stall_pct     = receiver_stall[ph];
         sent = 0;
         while (sent < PHASE_BYTES) begin
            send_random_instr(n);
            sent += n;
         end
         // sender holds off until every result word is back
         wait_drained();
      end

      stall_pct = 0;
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("** x86_mov_instruction_decoder_top: PASSED **");
      end else begin
         $display("** x86_mov_instruction_decoder_top: FAILED **");
      end
      $finish;
   end

endmodule
